>>> src/rvalu_pkg.sv
package rvalu_pkg;

    localparam int XLEN      = 32;
    localparam int REG_IDX_W = 5;
    localparam int CMD_W     = 4;

    localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFF_F000;
    localparam logic [XLEN-1:0] PC_STEP    = 32'd4;

    // Packed widths of the stream payloads, rounded up to whole bytes
    localparam int IN_BITS   = CMD_W + 3 * REG_IDX_W + XLEN;
    localparam int OUT_BITS  = REG_IDX_W + 2 * XLEN;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LUI   = 4'd0,
        CMD_AUIPC = 4'd1,
        CMD_AND   = 4'd2,
        CMD_OR    = 4'd3,
        CMD_XOR   = 4'd4,
        CMD_ANDI  = 4'd5,
        CMD_ORI   = 4'd6,
        CMD_XORI  = 4'd7,
        CMD_ADD   = 4'd8,
        CMD_SUB   = 4'd9,
        CMD_ADDI  = 4'd10
    } cmd_t;

    // Register file write request from the execute stage
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [XLEN-1:0]      data;
    } rf_wr_t;

endpackage

>>> src/rv32i_alu_subset_execute.sv
// Channel   Dir  Handshake         Payload (low bit first)
// s_*       in   s_tvalid/s_tready command[3:0] dest_reg[8:4] src1_reg[13:9]
//                                  src2_reg[18:14] immediate[50:19]
// m_*       out  m_tvalid/m_tready written_reg[4:0] written_value[36:5] instr_pc[68:37]
// start_pc  in   start_pc_we       start_pc_wdata[31:0]
//
// One instruction per clock sustained while the result side keeps m_tready high; a result
// passes the input register with register read, then executes into the result register.
// The register file is written as the result register loads, and the next
// instruction's read forwards that write, so back-to-back dependencies resolve.
// Reset clears the valid bits of the register file, the PC and both stage valids.
// A stalled result register holds; one further instruction waits in the read stage.
module rv32i_alu_subset_execute #(
    parameter int NUM_REGS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command, dest_reg, src1_reg, src2_reg, immediate
    input  logic [rvalu_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // written_reg, written_value, instr_pc
    output logic [rvalu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  start_pc_we,
    input  logic [rvalu_pkg::XLEN-1:0]            start_pc_wdata
);
    import rvalu_pkg::*;

    // Read stage
    logic                 s1_valid_reg;
    cmd_t                 s1_cmd_reg;
    logic [REG_IDX_W-1:0] s1_rd_reg;
    logic [XLEN-1:0]      s1_imm_reg;
    logic [XLEN-1:0]      s1_a;
    logic [XLEN-1:0]      s1_b;

    // Result register
    logic                 out_valid_reg;
    logic [REG_IDX_W-1:0] out_idx_reg;
    logic [XLEN-1:0]      out_value_reg;
    logic [XLEN-1:0]      out_pc_reg;

    logic [XLEN-1:0]      pc_reg;
    logic                 in_xfer;
    logic                 s1_adv;
    logic [XLEN-1:0]      alu_result;
    logic                 alu_known;
    logic                 rd_writable;
    rf_wr_t               rf_wr;

    // Stage handshakes
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_xfer  = s_tvalid && s_tready;

    rvalu_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_xfer),
        .rs1_idx  (s_tdata[13:9]),
        .rs2_idx  (s_tdata[18:14]),
        .wr       (rf_wr),
        .rs1_data (s1_a),
        .rs2_data (s1_b)
    );

    rvalu_alu u_alu (
        .cmd    (s1_cmd_reg),
        .op_a   (s1_a),
        .op_b   (s1_b),
        .imm    (s1_imm_reg),
        .pc     (pc_reg),
        .result (alu_result),
        .known  (alu_known)
    );

    // Destination is real only for a known command and only if nonzero and inside the file
    assign rd_writable = alu_known && (s1_rd_reg != '0)
        && ({1'b0, s1_rd_reg} < (REG_IDX_W+1)'(NUM_REGS));

    always_comb
    begin
        rf_wr.en   = s1_adv && rd_writable;
        rf_wr.idx  = s1_rd_reg;
        rf_wr.data = alu_result;
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg <= cmd_t'(s_tdata[3:0]);
            s1_rd_reg  <= s_tdata[8:4];
            s1_imm_reg <= s_tdata[50:19];
        end
    end

    // Program counter: loaded by config, steps once per executed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (start_pc_we)
        begin
            pc_reg <= start_pc_wdata;
        end
        else if (s1_adv)
        begin
            pc_reg <= pc_reg + PC_STEP;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_idx_reg   <= alu_known ? s1_rd_reg : '0;
            out_value_reg <= rd_writable ? alu_result : '0;
            out_pc_reg    <= pc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-OUT_BITS)'(0), out_pc_reg, out_value_reg, out_idx_reg};

endmodule

>>> src/rvalu_alu.sv
module rvalu_alu (
    input  rvalu_pkg::cmd_t               cmd,
    input  logic [rvalu_pkg::XLEN-1:0]    op_a,
    input  logic [rvalu_pkg::XLEN-1:0]    op_b,
    input  logic [rvalu_pkg::XLEN-1:0]    imm,
    input  logic [rvalu_pkg::XLEN-1:0]    pc,
    output logic [rvalu_pkg::XLEN-1:0]    result,
    output logic                          known
);
    import rvalu_pkg::*;

    // One operation per command; unknown codes give zero
    always_comb
    begin
        known = 1'b1;
        unique case (cmd)
            CMD_LUI:   result = imm & UPPER_MASK;
            CMD_AUIPC: result = pc + (imm & UPPER_MASK);
            CMD_AND:   result = op_a & op_b;
            CMD_OR:    result = op_a | op_b;
            CMD_XOR:   result = op_a ^ op_b;
            CMD_ANDI:  result = op_a & imm;
            CMD_ORI:   result = op_a | imm;
            CMD_XORI:  result = op_a ^ imm;
            CMD_ADD:   result = op_a + op_b;
            CMD_SUB:   result = op_a - op_b;
            CMD_ADDI:  result = op_a + imm;
            default:
            begin
                result = '0;
                known  = 1'b0;
            end
        endcase
    end

endmodule

>>> src/rvalu_regfile.sv
module rvalu_regfile #(
    parameter int NUM_REGS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [rvalu_pkg::REG_IDX_W-1:0]   rs1_idx,
    input  logic [rvalu_pkg::REG_IDX_W-1:0]   rs2_idx,
    input  rvalu_pkg::rf_wr_t                 wr,
    output logic [rvalu_pkg::XLEN-1:0]        rs1_data,
    output logic [rvalu_pkg::XLEN-1:0]        rs2_data
);
    import rvalu_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [XLEN-1:0]     mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [XLEN-1:0]     rs1_data_reg;
    logic [XLEN-1:0]     rs2_data_reg;
    logic                rs1_live;
    logic                rs2_live;
    logic                rs1_fwd;
    logic                rs2_fwd;

    // An index reads storage only if nonzero, in range and written since reset
    always_comb
    begin
        rs1_live = (rs1_idx != '0)
            && ({1'b0, rs1_idx} < (REG_IDX_W+1)'(NUM_REGS))
            && valid_reg[rs1_idx[AW-1:0]];
        rs2_live = (rs2_idx != '0)
            && ({1'b0, rs2_idx} < (REG_IDX_W+1)'(NUM_REGS))
            && valid_reg[rs2_idx[AW-1:0]];
        rs1_fwd  = wr.en && (wr.idx == rs1_idx);
        rs2_fwd  = wr.en && (wr.idx == rs2_idx);
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx[AW-1:0]] <= wr.data;
        end
    end

    // Valid bits stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx[AW-1:0]] <= 1'b1;
        end
    end

    // Registered read, write-first on a same-cycle hit
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (rs1_fwd)
                rs1_data_reg <= wr.data;
            else if (rs1_live)
                rs1_data_reg <= mem[rs1_idx[AW-1:0]];
            else
                rs1_data_reg <= '0;

            if (rs2_fwd)
                rs2_data_reg <= wr.data;
            else if (rs2_live)
                rs2_data_reg <= mem[rs2_idx[AW-1:0]];
            else
                rs2_data_reg <= '0;
        end
    end

    assign rs1_data = rs1_data_reg;
    assign rs2_data = rs2_data_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import rvalu_pkg::*;

    localparam int NUM_REGS       = 32;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int PRESSURE_ITEMS  = 24;

    // Command codes past the last defined operation
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_ADDI + 1);
    localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

    // One retired instruction as seen on the result stream
    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_idx;
        logic [XLEN-1:0]      value;
        logic [XLEN-1:0]      pc;
    } retire_t;

    // Architectural model of the register file and PC, plus the queue of
    // retirements still owed by the block
    class retire_scoreboard;
        logic [XLEN-1:0] regs [NUM_REGS];
        logic [XLEN-1:0] pc;
        retire_t         retire_q [$];
        int              errors;
        int              checked;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            pc      = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void load_pc(input logic [XLEN-1:0] value);
            pc = value;
        endfunction

        function logic [XLEN-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
            if (idx == 0 || idx >= NUM_REGS)
                return '0;
            return regs[idx];
        endfunction

        // Execute one accepted instruction and queue its retirement
        function void execute_instr(input logic [CMD_W-1:0] cmd,
                                    input logic [REG_IDX_W-1:0] rd,
                                    input logic [REG_IDX_W-1:0] rs1,
                                    input logic [REG_IDX_W-1:0] rs2,
                                    input logic [XLEN-1:0] imm);
            logic [XLEN-1:0] a;
            logic [XLEN-1:0] b;
            logic [XLEN-1:0] result;
            retire_t         ret;
            a = read_reg(rs1);
            b = read_reg(rs2);
            case (cmd)
                CMD_LUI:   result = imm & UPPER_MASK;
                CMD_AUIPC: result = pc + (imm & UPPER_MASK);
                CMD_AND:   result = a & b;
                CMD_OR:    result = a | b;
                CMD_XOR:   result = a ^ b;
                CMD_ANDI:  result = a & imm;
                CMD_ORI:   result = a | imm;
                CMD_XORI:  result = a ^ imm;
                CMD_ADD:   result = a + b;
                CMD_SUB:   result = a - b;
                CMD_ADDI:  result = a + imm;
                default:   result = '0;
            endcase
            ret.reg_idx = rd;
            ret.value   = result;
            ret.pc      = pc;
            if (cmd > CMD_ADDI)
            begin
                // unknown opcode: no write, reported as x0 / zero
                ret.reg_idx = '0;
                ret.value   = '0;
            end
            else if (rd == 0 || rd >= NUM_REGS)
            begin
                ret.value = '0;
            end
            else
            begin
                regs[rd] = result;
            end
            retire_q = {retire_q, ret};
            pc = pc + PC_STEP;
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Compare one result transaction with the oldest pending retirement
        task check_retire(input logic [OUT_TDATA_W-1:0] data);
            retire_t got;
            retire_t want;
            got.reg_idx = data[REG_IDX_W-1:0];
            got.value   = data[REG_IDX_W +: XLEN];
            got.pc      = data[REG_IDX_W + XLEN +: XLEN];
            checked++;
            if (retire_q.size() == 0)
            begin
                report($sformatf("unexpected result rd=%0d val=%h pc=%h",
                                 got.reg_idx, got.value, got.pc));
                return;
            end
            want = retire_q.pop_front();
            if (got.reg_idx !== want.reg_idx)
                report($sformatf("pc=%h written_reg got %0d want %0d",
                                 want.pc, got.reg_idx, want.reg_idx));
            if (got.value !== want.value)
                report($sformatf("pc=%h written_value got %h want %h",
                                 want.pc, got.value, want.value));
            if (got.pc !== want.pc)
                report($sformatf("instr_pc got %h want %h", got.pc, want.pc));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    start_pc_we;
    logic [XLEN-1:0]         start_pc_wdata;

    retire_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  items_sent;
    int  pc_loads;
    int  quiet_cycles;

    rv32i_alu_subset_execute #(
        .NUM_REGS(NUM_REGS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .start_pc_we    (start_pc_we),
        .start_pc_wdata (start_pc_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_retire(m_tdata);
    end

    // Watchdog: too many cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog expired, %0d results pending", $time,
                     sb.retire_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one instruction, with random idle cycles first, and wait for acceptance
    task automatic send_instr(input logic [CMD_W-1:0] cmd,
                              input logic [REG_IDX_W-1:0] rd,
                              input logic [REG_IDX_W-1:0] rs1,
                              input logic [REG_IDX_W-1:0] rs2,
                              input logic [XLEN-1:0] imm);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata = '0;
        s_tdata[IN_BITS-1:0] = {imm, rs2, rs1, rd, cmd};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.execute_instr(cmd, rd, rs1, rs2, imm);
        items_sent++;
    endtask

    // Mostly a small register window so that results feed later instructions
    function automatic logic [REG_IDX_W-1:0] pick_reg();
        if ($urandom_range(99, 0) < 70)
            return REG_IDX_W'($urandom_range(7, 0));
        return REG_IDX_W'($urandom_range(31, 0));
    endfunction

    task automatic send_random_instr();
        logic [CMD_W-1:0] cmd;
        logic [XLEN-1:0]  imm;
        int               r;
        r = $urandom_range(99, 0);
        if (r < 6)
            cmd = CMD_W'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
        else
            cmd = CMD_W'($urandom_range(CMD_ADDI, CMD_LUI));
        r = $urandom_range(99, 0);
        case ($urandom_range(7, 0))
            0: imm = '0;
            1: imm = '1;
            2: imm = 32'h7FFF_FFFF;
            3: imm = 32'h8000_0000;
            4: imm = 32'h0000_0FFF;
            default: imm = $urandom;
        endcase
        if (r >= 20)
            imm = $urandom;
        send_instr(cmd, pick_reg(), pick_reg(), pick_reg(), imm);
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.retire_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_start_pc(input logic [XLEN-1:0] value);
        wait_drained();
        @(negedge clk);
        start_pc_we    = 1'b1;
        start_pc_wdata = value;
        @(negedge clk);
        start_pc_we    = 1'b0;
        sb.load_pc(value);
        pc_loads++;
    endtask

    initial
    begin
        int              idle_tab  [4];
        int              stall_tab [4];
        logic [XLEN-1:0] pc_tab    [4];

        idle_tab  = '{0, 48, 0, 31};
        stall_tab = '{0, 0, 48, 31};
        pc_tab    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, $urandom};

        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        start_pc_we    = 1'b0;
        start_pc_wdata = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        items_sent     = 0;
        pc_loads       = 0;
        quiet_cycles   = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unaligned start PC, field extremes, every operation
        load_start_pc(32'h0000_0ABE);
        send_instr(CMD_LUI,   5'd1,  5'd0,  5'd0,  32'hFFFF_FFFF);
        send_instr(CMD_LUI,   5'd2,  5'd0,  5'd0,  32'h8000_0FFF);
        send_instr(CMD_ADDI,  5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF);
        send_instr(CMD_ADDI,  5'd4,  5'd3,  5'd0,  32'h0000_0001);
        send_instr(CMD_ADDI,  5'd5,  5'd0,  5'd0,  32'hFFFF_FFFF);
        send_instr(CMD_ADD,   5'd6,  5'd5,  5'd5,  32'h0);
        send_instr(CMD_SUB,   5'd7,  5'd0,  5'd5,  32'h0);
        send_instr(CMD_SUB,   5'd8,  5'd4,  5'd3,  32'h0);
        send_instr(CMD_AND,   5'd9,  5'd1,  5'd5,  32'h0);
        send_instr(CMD_OR,    5'd10, 5'd2,  5'd3,  32'h0);
        send_instr(CMD_XOR,   5'd11, 5'd5,  5'd3,  32'h0);
        send_instr(CMD_ANDI,  5'd12, 5'd5,  5'd0,  32'h0F0F_0F0F);
        send_instr(CMD_ORI,   5'd13, 5'd0,  5'd0,  32'h8000_0000);
        send_instr(CMD_XORI,  5'd14, 5'd5,  5'd0,  32'hFFFF_FFFF);
        // auipc keeps the low PC bits
        send_instr(CMD_AUIPC, 5'd15, 5'd0,  5'd0,  32'hFFFF_F123);
        // x0 as destination and as source
        send_instr(CMD_ADDI,  5'd0,  5'd5,  5'd0,  32'h0000_0005);
        send_instr(CMD_ADD,   5'd16, 5'd0,  5'd5,  32'h0);
        send_instr(CMD_AUIPC, 5'd0,  5'd0,  5'd0,  32'h1234_5000);
        // undefined opcodes
        send_instr(CMD_FIRST_UNUSED, 5'd31, 5'd5, 5'd5, 32'hFFFF_FFFF);
        send_instr(CMD_LAST_CODE,    5'd31, 5'd5, 5'd5, 32'hFFFF_FFFF);
        // back-to-back dependency chain on x31
        send_instr(CMD_ADD,   5'd31, 5'd31, 5'd5,  32'h0);
        send_instr(CMD_ADDI,  5'd31, 5'd31, 5'd0,  32'h0000_0001);
        send_instr(CMD_SUB,   5'd30, 5'd31, 5'd31, 32'h0);
        // PC wrap around the top of the address space
        load_start_pc(32'hFFFF_FFF6);
        send_instr(CMD_AUIPC, 5'd17, 5'd0,  5'd0,  32'h0000_1000);
        send_instr(CMD_AUIPC, 5'd18, 5'd0,  5'd0,  32'h0);
        send_instr(CMD_AUIPC, 5'd19, 5'd0,  5'd0,  32'hFFFF_FFFF);

        // Random phases with different idle and stall patterns and start PCs
        for (int p = 0; p < 4; p++)
        begin
            load_start_pc(pc_tab[p]);
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_instr();
        end

        // Back-pressure: result side holds off while instructions keep coming
        wait_drained();
        idle_pct  = 0;
        stall_pct = 20;
        hold_req  = 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_random_instr();
        wait_drained();
        for (int i = 0; i < PRESSURE_ITEMS / 2; i++)
            send_random_instr();

        wait_drained();
        if (sb.retire_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.retire_q.size()));

        $display("Executed %0d instructions, %0d results checked, %0d mismatches.",
                 items_sent, sb.checked, sb.errors);
        $display("Start PC loaded %0d times; idle, stall and long hold-off phases run.",
                 pc_loads);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
